[src/mhpq_pkg.sv]
// Types, codes and the ordering compare used by the heap priority queue top level.
package mhpq_pkg;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [15:0] id;
      logic [3:0]  prio;
      logic [31:0] arrival;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic        opcode;
      logic [15:0] entry_id;
      logic [3:0]  priority_req;
      logic [31:0] arrival_order;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_id;
      logic [3:0]  out_priority;
      logic [31:0] out_arrival;
      logic [5:0]  occupancy;
   } rsp_type;

   // True when entry a is served before entry b: lower priority, then lower arrival.
   function automatic logic served_before(entry_type a, entry_type b);
      return {a.prio, a.arrival} < {b.prio, b.arrival};
   endfunction

endpackage

[src/mhpq_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module mhpq_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[src/min_heap_priority_queue.sv]
// Binary min-heap priority queue top level: sequencer, shared compare and heap RAM.
// A full or empty reject is answered from idle. An enqueue climbs the heap level by level until
// a compare stops it or it reaches the root; a dequeue reads the root and the last entry, then
// sinks level by level until a compare stops it or no child remains. One beat at a time: busy
// drops in the rsp_strobe cycle, the receiver cannot stall it, and reset (synchronous, active
// high) empties the queue.
module min_heap_priority_queue #(
   parameter int HEAP_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mhpq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mhpq_pkg::rsp_type rsp_data
);
   import mhpq_pkg::*;

   localparam int ADDR_W = $clog2(HEAP_DEPTH);
   localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
   localparam int WIDE_W = ADDR_W + 2;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_UP      = 3'd1;
   localparam logic [2:0] ST_UP_CMP  = 3'd2;
   localparam logic [2:0] ST_DN_ROOT = 3'd3;
   localparam logic [2:0] ST_DN_LAST = 3'd4;
   localparam logic [2:0] ST_DN      = 3'd5;
   localparam logic [2:0] ST_DN_L    = 3'd6;
   localparam logic [2:0] ST_DN_R    = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] child_ff, child_in;   // left child index while sinking
   logic              lbest_ff, lbest_in;   // left child beat the moving entry
   entry_type         hold_ff, hold_in;     // the entry being sifted
   entry_type         best_ff, best_in;     // winner of the left-child compare
   entry_type         out_ff, out_in;       // dequeued entry, zero otherwise
   logic [1:0]        status_ff, status_in;
   logic              strobe_ff, strobe_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   entry_type         wr_data, rd_data;
   logic [ENTRY_W-1:0] rd_bits;

   entry_type         cmp_a, cmp_b;
   logic              cmp_lt;

   logic [WIDE_W-1:0] count_wide, pos_wide, left_wide, right_wide;
   logic [ADDR_W-1:0] parent_idx;
   logic [CNT_W+5:0]  occ_wide;
   entry_type         new_entry;

   mhpq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(HEAP_DEPTH)
   ) u_heap_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_bits)
   );

   assign rd_data = entry_type'(rd_bits);

   // The one key comparator, shared by the climb and the sink.
   assign cmp_lt = served_before(cmp_a, cmp_b);

   assign count_wide = {{(WIDE_W - CNT_W){1'b0}}, count_ff};
   assign pos_wide   = {2'b00, pos_ff};
   assign left_wide  = (pos_wide << 1) + WIDE_W'(1);
   assign right_wide = (pos_wide << 1) + WIDE_W'(2);
   assign parent_idx = (pos_ff - ADDR_W'(1)) >> 1;

   assign new_entry.id      = req_data.entry_id;
   assign new_entry.prio    = req_data.priority_req;
   assign new_entry.arrival = req_data.arrival_order;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      child_in  = child_ff;
      lbest_in  = lbest_ff;
      hold_in   = hold_ff;
      best_in   = best_ff;
      out_in    = out_ff;
      status_in = status_ff;
      strobe_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = hold_ff;
      rd_en     = 1'b0;
      rd_addr   = pos_ff;
      cmp_a     = hold_ff;
      cmp_b     = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               out_in    = '0;
               status_in = STATUS_OK;
               if (req_data.opcode == OP_ENQUEUE) begin
                  if (count_ff >= CNT_W'(HEAP_DEPTH)) begin
                     status_in = STATUS_FULL;
                     strobe_in = 1'b1;
                  end else begin
                     hold_in  = new_entry;
                     pos_in   = count_ff[ADDR_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                     state_in = ST_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     strobe_in = 1'b1;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     count_in = count_ff - CNT_W'(1);
                     state_in = ST_DN_ROOT;
                  end
               end
            end
         end

         ST_UP: begin
            if (pos_ff == '0) begin
               wr_en     = 1'b1;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent_idx;
               state_in = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            // Parent is on the read port; a lower key moves the parent down.
            wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data  = rd_data;
               pos_in   = parent_idx;
               state_in = ST_UP;
            end else begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         ST_DN_ROOT: begin
            out_in   = rd_data;
            rd_en    = 1'b1;
            rd_addr  = count_ff[ADDR_W-1:0];
            state_in = ST_DN_LAST;
         end

         ST_DN_LAST: begin
            hold_in  = rd_data;
            pos_in   = '0;
            state_in = ST_DN;
         end

         ST_DN: begin
            if (left_wide >= count_wide) begin
               wr_en     = 1'b1;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = left_wide[ADDR_W-1:0];
               child_in = left_wide[ADDR_W-1:0];
               state_in = ST_DN_L;
            end
         end

         ST_DN_L: begin
            cmp_a = rd_data;
            cmp_b = hold_ff;
            if (right_wide < count_wide) begin
               lbest_in = cmp_lt;
               best_in  = cmp_lt ? rd_data : hold_ff;
               rd_en    = 1'b1;
               rd_addr  = right_wide[ADDR_W-1:0];
               state_in = ST_DN_R;
            end else begin
               wr_en = 1'b1;
               if (cmp_lt) begin
                  wr_data  = rd_data;
                  pos_in   = child_ff;
                  state_in = ST_DN;
               end else begin
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end

         ST_DN_R: begin
            // The right child must beat the better of the left child and the moving entry.
            cmp_a = rd_data;
            cmp_b = best_ff;
            wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data  = rd_data;
               pos_in   = child_ff + ADDR_W'(1);
               state_in = ST_DN;
            end else if (lbest_ff) begin
               wr_data  = best_ff;
               pos_in   = child_ff;
               state_in = ST_DN;
            end else begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      pos_ff    <= pos_in;
      child_ff  <= child_in;
      lbest_ff  <= lbest_in;
      hold_ff   <= hold_in;
      best_ff   <= best_in;
      out_ff    <= out_in;
      status_ff <= status_in;
   end

   // Occupancy carries the low six bits of the count.
   assign occ_wide = {6'b000000, count_ff};

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_strobe            = strobe_ff;
   assign rsp_data.status       = status_ff;
   assign rsp_data.out_id       = out_ff.id;
   assign rsp_data.out_priority = out_ff.prio;
   assign rsp_data.out_arrival  = out_ff.arrival;
   assign rsp_data.occupancy    = occ_wide[5:0];

endmodule
